FILE: hdl/msld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimal standard LCG draws - shared definitions
// Widths, generator constants, codes, sequencer states and the control
// structures that pass between the sequencer, the arithmetic unit and the top.
// ----------------------------------------------------------------------------
package msld_pkg;

    // Number of uniform draws summed for one approximate normal value.
    localparam int unsigned NORMAL_DRAWS = 12;

    localparam int unsigned STATE_W = 31;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned SUM_W   = 36;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned OPND_W  = 32;
    localparam int unsigned PROD_W  = 2 * OPND_W;
    localparam int unsigned REM_W   = STATE_W + 1;
    localparam int unsigned FRAC_SH = 16;
    localparam int unsigned LOAD_W  = SUM_W + FRAC_SH;
    // Centered sum in Q16.16 spans +/- NORMAL_DRAWS * 2^15.
    localparam int unsigned Z_W     = 21;
    localparam int unsigned SCALED_W = PROD_W - FRAC_SH;
    localparam int unsigned NORM_W  = SCALED_W + 1;

    localparam logic [STATE_W-1:0] LCG_MOD = {STATE_W{1'b1}};
    localparam logic [STATE_W-1:0] LCG_MUL = STATE_W'(16807);
    localparam logic [REM_W-1:0]   LCG_MOD_EXT = {1'b0, LCG_MOD};
    localparam logic [STATE_W-1:0] STATE_ONE = STATE_W'(1);

    localparam logic [CNT_W-1:0] LAST_DRAW = CNT_W'(NORMAL_DRAWS - 1);
    localparam logic signed [Z_W-1:0] CENTER_OFFSET = Z_W'(NORMAL_DRAWS * 32768);

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Draw kinds.
    localparam logic [FUNC_W-1:0] FUNC_RAW     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BOUNDED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NORMAL  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

    typedef enum logic [2:0] {
        ARITH_HOLD,
        ARITH_MUL,
        ARITH_LOAD,
        ARITH_FOLD,
        ARITH_CORR
    } arith_op_t;

    typedef enum logic [1:0] {
        MSEL_GEN,
        MSEL_SCALE,
        MSEL_SPREAD
    } mul_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_GEN,
        RES_QUO,
        RES_NORM
    } res_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEN_MUL,
        ST_GEN_FOLD,
        ST_GEN_CORR,
        ST_ACCUM,
        ST_SCALE_MUL,
        ST_DIV_LOAD,
        ST_DIV_FOLD,
        ST_DIV_CORR,
        ST_CENTER,
        ST_SPREAD_MUL,
        ST_FINISH,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic      idle;
        arith_op_t op;
        mul_sel_t  msel;
        res_sel_t  res_sel;
        logic      res_upd;
        logic      gen_upd;
        logic      sum_clr;
        logic      sum_acc;
        logic      z_upd;
        logic      out_load;
    } msld_ctl_t;

    typedef struct packed {
        logic               rem_ge_m;
        logic [STATE_W-1:0] rem_mod;
    } msld_stat_t;

endpackage

FILE: hdl/msld_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimal standard LCG draws - channel interfaces
// Request, result and seed write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface msld_req_if
    import msld_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [STATE_W-1:0]        bound;
    logic signed [VALUE_W-1:0] mean_q16;
    logic [STATE_W-1:0]        spread_q16;

    modport source (output valid, func, bound, mean_q16, spread_q16, input ready);
    modport sink   (input valid, func, bound, mean_q16, spread_q16, output ready);
endinterface

interface msld_rsp_if
    import msld_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

interface msld_cfg_if
    import msld_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] seed;

    modport source (output valid, seed, input ready);
    modport sink   (input valid, seed, output ready);
endinterface

FILE: hdl/msld_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimal standard LCG draws - shared arithmetic unit
// One 32x32 signed multiplier plus a fold and compare-subtract stage that
// reduces a product modulo 2^31-1 and keeps the quotient alongside.
// ----------------------------------------------------------------------------
module msld_arith
    import msld_pkg::*;
(
    input  logic                      clk,
    input  arith_op_t                 op,
    input  logic [OPND_W-1:0]         mul_a,
    input  logic signed [OPND_W-1:0]  mul_b,
    input  logic [LOAD_W-1:0]         load_val,
    output logic signed [PROD_W-1:0]  prod,
    output logic [STATE_W-1:0]        quo,
    output msld_stat_t                stat
);

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [STATE_W-1:0]       quo_reg, quo_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic                     rem_ge_m;
    logic [REM_W-1:0]         rem_sub;

    assign rem_ge_m = (rem_reg >= LCG_MOD_EXT);
    assign rem_sub  = rem_reg - LCG_MOD_EXT;

    always_comb
    begin
        prod_next = prod_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        case (op)
            ARITH_MUL:
            begin
                prod_next = $signed(mul_a) * mul_b;
            end
            ARITH_LOAD:
            begin
                prod_next = $signed(PROD_W'(load_val));
            end
            ARITH_FOLD:
            begin
                // x = hi * 2^31 + lo, and 2^31 is one more than the modulus.
                quo_next = prod_reg[2*STATE_W-1:STATE_W];
                rem_next = {1'b0, prod_reg[STATE_W-1:0]}
                         + {1'b0, prod_reg[2*STATE_W-1:STATE_W]};
            end
            ARITH_CORR:
            begin
                if (rem_ge_m)
                begin
                    rem_next = rem_sub;
                    quo_next = quo_reg + STATE_ONE;
                end
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign prod          = prod_reg;
    assign quo           = quo_reg;
    assign stat.rem_ge_m = rem_ge_m;
    assign stat.rem_mod  = rem_ge_m ? rem_sub[STATE_W-1:0] : rem_reg[STATE_W-1:0];

endmodule

FILE: hdl/msld_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimal standard LCG draws - sequencer
// Steps the shared arithmetic unit through generator advances, the bounded
// scaling and the normal-draw accumulation, then hands the result on.
// ----------------------------------------------------------------------------
module msld_ctrl
    import msld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_fire,
    input  logic [FUNC_W-1:0] req_func,
    input  msld_stat_t        stat,
    input  logic              out_free,
    output msld_ctl_t         ctl
);

    seq_state_t        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            func_reg  <= FUNC_RAW;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            count_reg <= count_next;
        end
    end

    // Next state and the draw counter.
    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    func_next  = req_func;
                    count_next = '0;
                    state_next = (req_func == FUNC_NONE) ? ST_DONE : ST_GEN_MUL;
                end
            end
            ST_GEN_MUL:    state_next = ST_GEN_FOLD;
            ST_GEN_FOLD:   state_next = ST_GEN_CORR;
            ST_GEN_CORR:
            begin
                case (func_reg)
                    FUNC_RAW:     state_next = ST_DONE;
                    FUNC_BOUNDED: state_next = ST_SCALE_MUL;
                    default:      state_next = ST_ACCUM;
                endcase
            end
            ST_ACCUM:
            begin
                if (count_reg == LAST_DRAW)
                begin
                    count_next = '0;
                    state_next = ST_DIV_LOAD;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_GEN_MUL;
                end
            end
            ST_SCALE_MUL:  state_next = ST_DIV_FOLD;
            ST_DIV_LOAD:   state_next = ST_DIV_FOLD;
            ST_DIV_FOLD:   state_next = ST_DIV_CORR;
            ST_DIV_CORR:
            begin
                if (!stat.rem_ge_m)
                begin
                    state_next = (func_reg == FUNC_BOUNDED) ? ST_DONE : ST_CENTER;
                end
            end
            ST_CENTER:     state_next = ST_SPREAD_MUL;
            ST_SPREAD_MUL: state_next = ST_FINISH;
            ST_FINISH:     state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Control strobes for the datapath.
    always_comb
    begin
        ctl          = '0;
        ctl.op       = ARITH_HOLD;
        ctl.msel     = MSEL_GEN;
        ctl.res_sel  = RES_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.idle = 1'b1;
                if (req_fire)
                begin
                    ctl.sum_clr = 1'b1;
                    if (req_func == FUNC_NONE)
                    begin
                        ctl.res_upd = 1'b1;
                        ctl.res_sel = RES_ZERO;
                    end
                end
            end
            ST_GEN_MUL:
            begin
                ctl.op   = ARITH_MUL;
                ctl.msel = MSEL_GEN;
            end
            ST_GEN_FOLD:   ctl.op = ARITH_FOLD;
            ST_GEN_CORR:
            begin
                ctl.gen_upd = 1'b1;
                if (func_reg == FUNC_RAW)
                begin
                    ctl.res_upd = 1'b1;
                    ctl.res_sel = RES_GEN;
                end
            end
            ST_ACCUM:      ctl.sum_acc = 1'b1;
            ST_SCALE_MUL:
            begin
                ctl.op   = ARITH_MUL;
                ctl.msel = MSEL_SCALE;
            end
            ST_DIV_LOAD:   ctl.op = ARITH_LOAD;
            ST_DIV_FOLD:   ctl.op = ARITH_FOLD;
            ST_DIV_CORR:
            begin
                if (stat.rem_ge_m)
                begin
                    ctl.op = ARITH_CORR;
                end
                else if (func_reg == FUNC_BOUNDED)
                begin
                    ctl.res_upd = 1'b1;
                    ctl.res_sel = RES_QUO;
                end
            end
            ST_CENTER:     ctl.z_upd = 1'b1;
            ST_SPREAD_MUL:
            begin
                ctl.op   = ARITH_MUL;
                ctl.msel = MSEL_SPREAD;
            end
            ST_FINISH:
            begin
                ctl.res_upd = 1'b1;
                ctl.res_sel = RES_NORM;
            end
            ST_DONE:       ctl.out_load = out_free;
            default:       ctl.op = ARITH_HOLD;
        endcase
    end

endmodule

FILE: hdl/minimal_standard_lcg_draws_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimal standard LCG draws unit
// Park-Miller generator (state * 16807 mod 2^31-1) serving raw, bounded
// integer and approximate normal draws, one result item per request item.
// ----------------------------------------------------------------------------
// Each request item yields exactly one result item. Mode 0 advances the
// generator once and returns the new 31-bit state. Mode 1 advances once and
// returns floor(state * bound / (2^31-1)); a bound of zero gives zero. Mode 2
// advances twelve times, sums the states, centers the sum and scales it by
// spread_q16 in Q16.16, adds mean_q16 and clips to the signed 32-bit range,
// raising saturated when it clips. Selector value 3 returns zero and leaves
// the generator alone. Multiplications and reductions run through one shared
// unit: a 32x32 multiplier followed by a fold and compare-subtract reduction
// modulo 2^31-1. A generator step runs multiply, fold and correct, then
// accumulate or dispatch; the reduction of a division folds, then subtracts
// the modulus while the remainder is not below it. req.ready is low while an
// accepted item is busy, including the final cycle in which the result moves
// to the output register. That final cycle stretches while the output
// register still holds a result that the receiver has not taken. The result
// sits in an output register, so a waiting result does not block the next
// request once it has been handed over. Writing the seed reloads the
// generator at once; a seed of zero or of 2^31-1 loads state one. Seed
// writes are meant for an idle block and are taken only while no request
// is in flight.
// ----------------------------------------------------------------------------
module minimal_standard_lcg_draws_unit
    import msld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    msld_cfg_if.sink     cfg,
    msld_req_if.sink     req,
    msld_rsp_if.source   rsp
);

    msld_ctl_t  ctl;
    msld_stat_t stat;

    logic req_fire;
    logic cfg_fire;
    logic out_free;

    // Generator and normal-draw state.
    logic [STATE_W-1:0]        gen_state_reg, gen_state_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic signed [Z_W-1:0]     z_reg, z_next;

    // Captured request operands.
    logic [STATE_W-1:0]        bound_reg;
    logic signed [VALUE_W-1:0] mean_reg;
    logic [STATE_W-1:0]        spread_reg;

    // Result waiting to be handed to the output register.
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic                      res_sat_reg, res_sat_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_sat_reg;

    // Shared unit operands and results.
    logic [OPND_W-1:0]         mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [STATE_W-1:0]        quo;

    // Normal result arithmetic.
    logic signed [SCALED_W-1:0] scaled;
    logic signed [NORM_W-1:0]   norm_sum;
    logic                       norm_ovf;
    logic signed [VALUE_W-1:0]  norm_value;

    assign req_fire = req.valid && req.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = ctl.idle;
    assign cfg.ready = ctl.idle;

    msld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .req_func (req.func),
        .stat     (stat),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (ctl.msel)
            MSEL_SCALE:
            begin
                mul_a = {1'b0, gen_state_reg};
                mul_b = $signed({1'b0, bound_reg});
            end
            MSEL_SPREAD:
            begin
                mul_a = {1'b0, spread_reg};
                mul_b = {{(OPND_W-Z_W){z_reg[Z_W-1]}}, z_reg};
            end
            default:
            begin
                mul_a = {1'b0, gen_state_reg};
                mul_b = $signed({1'b0, LCG_MUL});
            end
        endcase
    end

    // Sum of states shifted into Q16 before the division by the modulus.
    msld_arith u_arith (
        .clk      (clk),
        .op       (ctl.op),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .load_val ({sum_reg, {FRAC_SH{1'b0}}}),
        .prod     (prod),
        .quo      (quo),
        .stat     (stat)
    );

    // Generator state: a seed write reloads it, a finished step advances it.
    always_comb
    begin
        gen_state_next = gen_state_reg;
        if (cfg_fire)
        begin
            if ((cfg.seed == '0) || (cfg.seed == LCG_MOD))
            begin
                gen_state_next = STATE_ONE;
            end
            else
            begin
                gen_state_next = cfg.seed;
            end
        end
        else if (ctl.gen_upd)
        begin
            gen_state_next = stat.rem_mod;
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.sum_clr)
        begin
            sum_next = '0;
        end
        else if (ctl.sum_acc)
        begin
            sum_next = sum_reg + SUM_W'(gen_state_reg);
        end
    end

    // floor(sum * 2^16 / m) minus the mean of the sum gives the centered
    // value; the division works on the nonnegative sum, and the mean is taken
    // off after it.
    assign z_next = $signed({1'b0, quo[Z_W-2:0]}) - CENTER_OFFSET;

    // Arithmetic right shift of the product is the floor division by 2^16.
    assign scaled   = prod[PROD_W-1:FRAC_SH];
    assign norm_sum = NORM_W'(mean_reg) + NORM_W'(scaled);
    assign norm_ovf = (norm_sum[NORM_W-1:VALUE_W-1] != {(NORM_W-VALUE_W+1){norm_sum[NORM_W-1]}});
    assign norm_value = norm_ovf ? (norm_sum[NORM_W-1] ? VALUE_MIN : VALUE_MAX)
                                 : norm_sum[VALUE_W-1:0];

    always_comb
    begin
        res_value_next = res_value_reg;
        res_sat_next   = res_sat_reg;
        if (ctl.res_upd)
        begin
            case (ctl.res_sel)
                RES_GEN:
                begin
                    res_value_next = $signed({1'b0, stat.rem_mod});
                    res_sat_next   = 1'b0;
                end
                RES_QUO:
                begin
                    res_value_next = $signed({1'b0, quo});
                    res_sat_next   = 1'b0;
                end
                RES_NORM:
                begin
                    res_value_next = norm_value;
                    res_sat_next   = norm_ovf;
                end
                default:
                begin
                    res_value_next = '0;
                    res_sat_next   = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= STATE_ONE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gen_state_reg <= gen_state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            bound_reg  <= req.bound;
            mean_reg   <= req.mean_q16;
            spread_reg <= req.spread_q16;
        end
        if (ctl.z_upd)
        begin
            z_reg <= z_next;
        end
        res_value_reg <= res_value_next;
        res_sat_reg   <= res_sat_next;
        if (ctl.out_load)
        begin
            out_value_reg <= res_value_reg;
            out_sat_reg   <= res_sat_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value     = out_value_reg;
    assign rsp.saturated = out_sat_reg;

    // The generator state never reaches zero, which would lock it there.
    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_state_reg != '0)
        else $error("generator state reached zero");

    // An accepted request makes the unit busy and takes req.ready low.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request taken while previous one still in work");

    // A clipped normal result sits at one end of the signed range.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.saturated) |-> ((rsp.value == VALUE_MAX) || (rsp.value == VALUE_MIN)))
        else $error("saturated result not at a range limit");

endmodule
